// ===== design/fpd_pkg.sv =====
// Shared types, register indexes and constants for the flight phase detector.
package fpd_pkg;

    // Field widths
    localparam int ALT_W   = 24;
    localparam int VS_W    = 16;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 23;
    localparam int SINK_W  = 15;
    localparam int PHASE_W = 2;

    // Stream and config port widths
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Bit positions in the result tdata
    localparam int M_PHASE_LSB = 0;
    localparam int M_PEAK_LSB  = PHASE_W;

    // Jump phases
    typedef enum logic [PHASE_W-1:0] {
        PH_GROUND   = 2'd0,
        PH_FLIGHT   = 2'd1,
        PH_FREEFALL = 2'd2,
        PH_CANOPY   = 2'd3
    } phase_t;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_ALT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_DROP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_SINK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CANOPY_DIRECT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CANOPY_AFTER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LANDING_ALT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LANDING_HOLD   = 3'd7;

    // Fixed speed thresholds, sixteenths of ft/s (10 ft/s and 8 ft/s)
    localparam logic [VS_W:0] FREEFALL_SLOW = 17'd160;
    localparam logic [VS_W:0] LANDING_STILL = 17'd128;

    // Configuration registers
    typedef struct packed {
        logic [DIST_W-1:0]        climb_altitude;
        logic [TIME_W-1:0]        climb_hold_ms;
        logic [DIST_W-1:0]        freefall_drop;
        logic [SINK_W-1:0]        freefall_sink;
        logic [DIST_W-1:0]        canopy_direct_drop;
        logic [DIST_W-1:0]        canopy_after_freefall_drop;
        logic signed [ALT_W-1:0]  landing_altitude;
        logic [TIME_W-1:0]        landing_hold_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        climb_altitude:             23'd8000,
        climb_hold_ms:              32'd2000,
        freefall_drop:              23'd4800,
        freefall_sink:              15'd800,
        canopy_direct_drop:         23'd24000,
        canopy_after_freefall_drop: 23'd16000,
        landing_altitude:           24'sd16000,
        landing_hold_ms:            32'd5000
    };

    // Tracker state carried from sample to sample
    typedef struct packed {
        phase_t                   phase;
        logic signed [ALT_W-1:0]  peak;
        logic [TIME_W-1:0]        climb_start;
        logic                     climb_valid;
        logic [TIME_W-1:0]        still_start;
        logic                     still_valid;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_GROUND,
        peak:        24'sd0,
        climb_start: 32'd0,
        climb_valid: 1'b0,
        still_start: 32'd0,
        still_valid: 1'b0
    };

endpackage

// ===== design/fpd_step.sv =====
// Next-state logic for one altimeter sample: timers, phase rules and peak.
module fpd_step
(
    input  fpd_pkg::cfg_t                   cfg,
    input  fpd_pkg::state_t                 state_cur,
    input  logic signed [fpd_pkg::ALT_W-1:0] altitude,
    input  logic signed [fpd_pkg::VS_W-1:0]  vertical_speed,
    input  logic [fpd_pkg::TIME_W-1:0]      now_ms,
    output fpd_pkg::state_t                 state_nxt
);

    logic signed [fpd_pkg::ALT_W:0]   alt25;
    logic signed [fpd_pkg::ALT_W:0]   climb25;
    logic                             above_climb;
    logic                             below_climb;
    logic signed [fpd_pkg::ALT_W+1:0] alt26;
    logic signed [fpd_pkg::ALT_W+1:0] peak26;
    logic signed [fpd_pkg::ALT_W+1:0] ff_limit;
    logic signed [fpd_pkg::ALT_W+1:0] direct_limit;
    logic signed [fpd_pkg::ALT_W+1:0] after_limit;
    logic signed [fpd_pkg::VS_W:0]    vs17;
    logic signed [fpd_pkg::VS_W:0]    neg_sink;
    logic [fpd_pkg::VS_W:0]           speed_mag;
    logic [fpd_pkg::TIME_W-1:0]       climb_elapsed;
    logic [fpd_pkg::TIME_W-1:0]       still_elapsed;
    fpd_pkg::state_t                  st;

    // Widened operands for exact signed compares
    assign alt25   = $signed({altitude[fpd_pkg::ALT_W-1], altitude});
    assign climb25 = $signed({2'b00, cfg.climb_altitude});
    assign alt26   = $signed({{2{altitude[fpd_pkg::ALT_W-1]}}, altitude});
    assign vs17    = $signed({vertical_speed[fpd_pkg::VS_W-1], vertical_speed});
    assign neg_sink = 17'sd0 - $signed({2'b00, cfg.freefall_sink});
    assign speed_mag = vs17[fpd_pkg::VS_W] ? 17'(17'sd0 - vs17) : 17'(vs17);

    assign above_climb = alt25 > climb25;
    assign below_climb = alt25 < climb25;

    // Rules in fixed order; each one sees the result of the previous one
    always_comb
    begin
        st = state_cur;

        // Climb timer: starts above threshold, stops below, holds when equal
        if (above_climb && !st.climb_valid)
        begin
            st.climb_start = now_ms;
            st.climb_valid = 1'b1;
        end
        else if (below_climb)
        begin
            st.climb_start = '0;
            st.climb_valid = 1'b0;
        end
        climb_elapsed = now_ms - st.climb_start;
        if (st.phase == fpd_pkg::PH_GROUND && above_climb &&
            climb_elapsed > cfg.climb_hold_ms)
        begin
            st.phase = fpd_pkg::PH_FLIGHT;
        end

        // Peak tracking in flight
        if (st.phase == fpd_pkg::PH_FLIGHT && altitude > st.peak)
        begin
            st.peak = altitude;
        end

        peak26       = $signed({{2{st.peak[fpd_pkg::ALT_W-1]}}, st.peak});
        ff_limit     = peak26 - $signed({3'b000, cfg.freefall_drop});
        direct_limit = peak26 - $signed({3'b000, cfg.canopy_direct_drop});
        after_limit  = peak26 - $signed({3'b000, cfg.canopy_after_freefall_drop});

        // Drop below peak with fast sink
        if (st.phase == fpd_pkg::PH_FLIGHT && alt26 < ff_limit && vs17 < neg_sink)
        begin
            st.phase = fpd_pkg::PH_FREEFALL;
        end

        // Large drop straight to canopy
        if (st.phase == fpd_pkg::PH_FLIGHT && alt26 < direct_limit)
        begin
            st.phase = fpd_pkg::PH_CANOPY;
        end

        // Freefall slowed down well below peak
        if (st.phase == fpd_pkg::PH_FREEFALL && alt26 < after_limit &&
            speed_mag < fpd_pkg::FREEFALL_SLOW)
        begin
            st.phase = fpd_pkg::PH_CANOPY;
        end

        // Landing: low and still for long enough
        still_elapsed = now_ms - st.still_start;
        if (altitude < cfg.landing_altitude && speed_mag < fpd_pkg::LANDING_STILL)
        begin
            if (!st.still_valid)
            begin
                st.still_start = now_ms;
                st.still_valid = 1'b1;
            end
            else if (still_elapsed > cfg.landing_hold_ms)
            begin
                st.phase = fpd_pkg::PH_GROUND;
                st.peak  = '0;
            end
        end
        else
        begin
            st.still_start = '0;
            st.still_valid = 1'b0;
        end

        state_nxt = st;
    end

endmodule

// ===== design/flight_phase_detector_unit.sv =====
// Top level of the flight phase detector: stream ports, registers, config.
//
// Usage:
//   Slave stream (s_*) takes one altimeter sample per transaction:
//   altitude, vertical speed and a millisecond timestamp. Master stream
//   (m_*) returns one result per sample: the phase after the update and
//   the peak altitude of the current flight. The cfg channel writes the
//   eight threshold registers by index; it is always ready and must only
//   be used while no sample is in flight.
//   Path: an accepted sample is registered in the input stage, evaluated
//   by the step logic and registered in the result stage (m_tdata, m_tvalid).
//   Throughput: one sample per cycle while m_tready keeps the result
//   draining; the whole update is one pass of compares and subtracts
//   between the input and result registers, with the tracker state
//   written back in the same cycle.
//   Reset: phase goes to ground, peak to zero, both timers stop and the
//   registers take their default thresholds. Both stages come up empty.
//   Stall: while m_tready is low the result holds; the input stage still
//   takes one more sample, then s_tready drops until the result drains.
module flight_phase_detector_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fpd_pkg::S_DATA_W-1:0]     s_tdata,   // altitude[23:0], vertical_speed[39:24], now_ms[71:40]
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fpd_pkg::M_DATA_W-1:0]     m_tdata,   // phase[1:0], peak_altitude[25:2], zero[31:26]
    // Register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpd_pkg::CFG_DAT_W-1:0]    cfg_data
);

    logic                              in_valid_reg;
    logic signed [fpd_pkg::ALT_W-1:0]  in_alt_reg;
    logic signed [fpd_pkg::VS_W-1:0]   in_vs_reg;
    logic [fpd_pkg::TIME_W-1:0]        in_now_reg;
    logic                              out_valid_reg;
    fpd_pkg::phase_t                   out_phase_reg;
    logic signed [fpd_pkg::ALT_W-1:0]  out_peak_reg;
    fpd_pkg::cfg_t                     cfg_reg;
    fpd_pkg::state_t                   state_reg;
    fpd_pkg::state_t                   state_next;
    logic                              advance;

    // Handshake: evaluate when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_alt_reg <= $signed(s_tdata[23:0]);
            in_vs_reg  <= $signed(s_tdata[39:24]);
            in_now_reg <= s_tdata[71:40];
        end
    end

    // Per-sample update
    fpd_step u_step
    (
        .cfg            (cfg_reg),
        .state_cur      (state_reg),
        .altitude       (in_alt_reg),
        .vertical_speed (in_vs_reg),
        .now_ms         (in_now_reg),
        .state_nxt      (state_next)
    );

    // Tracker state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpd_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_phase_reg <= state_next.phase;
            out_peak_reg  <= state_next.peak;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= fpd_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fpd_pkg::REG_CLIMB_ALT:
                    cfg_reg.climb_altitude <= cfg_data[fpd_pkg::DIST_W-1:0];
                fpd_pkg::REG_CLIMB_HOLD:
                    cfg_reg.climb_hold_ms <= cfg_data[fpd_pkg::TIME_W-1:0];
                fpd_pkg::REG_FREEFALL_DROP:
                    cfg_reg.freefall_drop <= cfg_data[fpd_pkg::DIST_W-1:0];
                fpd_pkg::REG_FREEFALL_SINK:
                    cfg_reg.freefall_sink <= cfg_data[fpd_pkg::SINK_W-1:0];
                fpd_pkg::REG_CANOPY_DIRECT:
                    cfg_reg.canopy_direct_drop <= cfg_data[fpd_pkg::DIST_W-1:0];
                fpd_pkg::REG_CANOPY_AFTER:
                    cfg_reg.canopy_after_freefall_drop <= cfg_data[fpd_pkg::DIST_W-1:0];
                fpd_pkg::REG_LANDING_ALT:
                    cfg_reg.landing_altitude <= $signed(cfg_data[fpd_pkg::ALT_W-1:0]);
                fpd_pkg::REG_LANDING_HOLD:
                    cfg_reg.landing_hold_ms <= cfg_data[fpd_pkg::TIME_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_peak_reg, out_phase_reg};

endmodule

// ===== design/fpd_checker.sv =====
// Port-level checks for the flight phase detector, bound to the top level.
module fpd_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fpd_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [fpd_pkg::PHASE_W-1:0] phase_now;
    logic [fpd_pkg::ALT_W-1:0]   peak_now;
    logic [fpd_pkg::PHASE_W-1:0] last_phase_reg;
    logic                        m_xfer;

    assign phase_now = m_tdata[fpd_pkg::M_PHASE_LSB +: fpd_pkg::PHASE_W];
    assign peak_now  = m_tdata[fpd_pkg::M_PEAK_LSB +: fpd_pkg::ALT_W];
    assign m_xfer    = m_tvalid && m_tready;

    // Phase of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= fpd_pkg::PH_GROUND;
        end
        else if (m_xfer)
        begin
            last_phase_reg <= phase_now;
        end
    end

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // On the ground the peak has been cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && phase_now == fpd_pkg::PH_GROUND |-> peak_now == '0)
        else $error("nonzero peak in ground phase");

    // From ground only flight can follow
    assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && last_phase_reg == fpd_pkg::PH_GROUND |->
            phase_now == fpd_pkg::PH_GROUND || phase_now == fpd_pkg::PH_FLIGHT)
        else $error("illegal phase step out of ground");

    // Canopy ends only in ground, freefall never returns to flight
    assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && (last_phase_reg == fpd_pkg::PH_CANOPY ||
                   last_phase_reg == fpd_pkg::PH_FREEFALL) |->
            phase_now != fpd_pkg::PH_FLIGHT &&
            !(last_phase_reg == fpd_pkg::PH_CANOPY && phase_now == fpd_pkg::PH_FREEFALL))
        else $error("illegal phase step after exit");

    // Input handshake is always ready while the result stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

endmodule

bind flight_phase_detector_unit fpd_checker u_fpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_flight_phase_detector_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flight_phase_detector_unit: jump profiles, noise, config sweeps.
module tb_flight_phase_detector_unit;
    import fpd_pkg::*;

    localparam int     IDLE_LIMIT  = 2000;
    localparam int     MAX_REPORTS = 10;
    localparam int     NUM_PHASES  = 8;
    localparam int     PHASE_ITEMS = 215;
    localparam int     LONG_HOLD   = 60;
    localparam int     TAIL_CYCLES = 8;
    localparam int     NUM_REGS    = 2 ** CFG_IDX_W;
    localparam longint ALT_MIN     = -8388608;
    localparam longint ALT_MAX     = 8388607;
    localparam longint VS_MIN      = -32768;
    localparam longint VS_MAX      = 32767;

    // One altimeter sample, laid out as on s_tdata
    typedef struct packed {
        logic [TIME_W-1:0]       now_ms;
        logic signed [VS_W-1:0]  vertical_speed;
        logic signed [ALT_W-1:0] altitude;
    } sample_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] peak;
        phase_t                  phase;
    } phase_report_t;

    // Tracks the jump phase per sample and checks the results in order
    class phase_scoreboard;
        cfg_t                    regs;
        phase_t                  phase;
        logic signed [ALT_W-1:0] peak;
        logic [TIME_W-1:0]       climb_start;
        logic                    climb_valid;
        logic [TIME_W-1:0]       still_start;
        logic                    still_valid;
        phase_report_t           expected_q[$];
        int                      errors;

        function new();
            regs        = CFG_RESET;
            phase       = PH_GROUND;
            peak        = '0;
            climb_start = '0;
            climb_valid = 1'b0;
            still_start = '0;
            still_valid = 1'b0;
            errors      = 0;
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_CLIMB_ALT:     regs.climb_altitude             = data[DIST_W-1:0];
                REG_CLIMB_HOLD:    regs.climb_hold_ms              = data[TIME_W-1:0];
                REG_FREEFALL_DROP: regs.freefall_drop              = data[DIST_W-1:0];
                REG_FREEFALL_SINK: regs.freefall_sink              = data[SINK_W-1:0];
                REG_CANOPY_DIRECT: regs.canopy_direct_drop         = data[DIST_W-1:0];
                REG_CANOPY_AFTER:  regs.canopy_after_freefall_drop = data[DIST_W-1:0];
                REG_LANDING_ALT:   regs.landing_altitude           = data[ALT_W-1:0];
                REG_LANDING_HOLD:  regs.landing_hold_ms            = data[TIME_W-1:0];
            endcase
        endfunction

        // Advance the phase tracker by one accepted sample
        function void track_sample(sample_t smp);
            longint            alt, vs, mag, climb, pk;
            logic [TIME_W-1:0] now, elapsed;
            phase_report_t     res;
            alt   = smp.altitude;
            vs    = smp.vertical_speed;
            now   = smp.now_ms;
            mag   = (vs < 0) ? -vs : vs;
            climb = longint'(regs.climb_altitude);

            // climb timer: start above, stop below, hold when equal
            if (alt > climb && !climb_valid) begin
                climb_start = now;
                climb_valid = 1'b1;
            end
            else if (alt < climb) begin
                climb_valid = 1'b0;
                climb_start = '0;
            end
            elapsed = now - climb_start;
            if (phase == PH_GROUND && alt > climb && elapsed > regs.climb_hold_ms)
                phase = PH_FLIGHT;

            pk = peak;
            if (phase == PH_FLIGHT && alt > pk) begin
                peak = alt[ALT_W-1:0];
                pk   = alt;
            end

            // exit with fast sink
            if (phase == PH_FLIGHT && alt < pk - longint'(regs.freefall_drop) &&
                vs < -longint'(regs.freefall_sink))
                phase = PH_FREEFALL;

            // big drop without an exit
            if (phase == PH_FLIGHT && alt < pk - longint'(regs.canopy_direct_drop))
                phase = PH_CANOPY;

            // deployment: deep enough and slowed down
            if (phase == PH_FREEFALL && alt < pk - longint'(regs.canopy_after_freefall_drop) &&
                mag < longint'(FREEFALL_SLOW))
                phase = PH_CANOPY;

            // landing: low and still long enough
            if (alt < longint'($signed(regs.landing_altitude)) && mag < longint'(LANDING_STILL)) begin
                elapsed = now - still_start;
                if (!still_valid) begin
                    still_start = now;
                    still_valid = 1'b1;
                end
                else if (elapsed > regs.landing_hold_ms) begin
                    phase = PH_GROUND;
                    peak  = '0;
                end
            end
            else begin
                still_valid = 1'b0;
                still_start = '0;
            end

            res.phase = phase;
            res.peak  = peak;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] tdata);
            phase_report_t got, want;
            got.phase = phase_t'(tdata[M_PHASE_LSB +: PHASE_W]);
            got.peak  = tdata[M_PEAK_LSB +: ALT_W];
            if (expected_q.size() == 0) begin
                report_error($sformatf("result with nothing pending: phase %0d peak %0d",
                                       got.phase, got.peak));
                return;
            end
            want = expected_q.pop_front();
            if (got.phase !== want.phase)
                report_error($sformatf("phase expected %0d, got %0d", want.phase, got.phase));
            if (got.peak !== want.peak)
                report_error($sformatf("peak expected %0d, got %0d", want.peak, got.peak));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    phase_scoreboard       sb;
    logic [TIME_W-1:0]     clock_ms;
    int                    snd_gap_max  = 6;
    int                    rcv_gap_max  = 6;
    int                    rcv_hold_req = 0;
    int                    samples_sent = 0;
    int                    idle_cycles  = 0;

    flight_phase_detector_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint rand_between(longint lo, longint hi);
        return lo + longint'($urandom_range(hi - lo, 0));
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Offer one sample after a random gap; returns once the transaction is taken
    task automatic send_sample(input longint alt, input longint vs, input longint dt);
        sample_t smp;
        longint  a_c, v_c;
        int      w;
        clock_ms           = clock_ms + dt[TIME_W-1:0];
        a_c                = clamp(alt, ALT_MIN, ALT_MAX);
        v_c                = clamp(vs, VS_MIN, VS_MAX);
        smp.altitude       = a_c[ALT_W-1:0];
        smp.vertical_speed = v_c[VS_W-1:0];
        smp.now_ms         = clock_ms;
        w = $urandom_range(snd_gap_max, 0);
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tdata  <= smp;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        samples_sent++;
    endtask

    // Stop sending and wait until every pending result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Monitor: record samples, check results, mirror register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.track_sample(sample_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Watchdog: too long without any transaction
    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready) &&
            !(cfg_valid && cfg_ready))
            idle_cycles = idle_cycles + 1;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("flight_phase_detector_unit regression: fail");
            $finish;
        end
    end

    // Result side: random backpressure, plus a long hold on request
    initial
    begin : result_sink
        int w;
        forever
        begin
            if (rcv_hold_req > 0)
            begin
                w            = rcv_hold_req;
                rcv_hold_req = 0;
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            w = $urandom_range(rcv_gap_max, 0);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin : stimulus
        logic [CFG_DAT_W-1:0] reg_vals [NUM_REGS];
        longint               ca, ff, sink, cd, caf, la, alt, pk, from_alt, to_alt, dt_ms, n;
        int                   stop_at;

        sb       = new();
        clock_ms = 32'hFFFF_FC00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default thresholds. Field extremes first.
        send_sample(ALT_MIN, VS_MIN, 0);
        send_sample(ALT_MAX, VS_MAX, 1);
        // at the climb altitude the timer holds
        send_sample(8000, 0, 500);
        send_sample(8001, 100, 1100);
        // timestamp wraps past zero, hold just exceeded
        send_sample(8001, 100, 401);
        send_sample(40000, 500, 1000);
        // freefall boundaries: exactly at drop and sink, then one past
        send_sample(35200, -800, 100);
        send_sample(35199, -801, 100);
        // deployment boundaries: exactly at drop, speed exactly at slow limit
        send_sample(24000, -159, 100);
        send_sample(23999, -160, 100);
        send_sample(23999, 159, 100);
        // landing: speed at still limit, then hold exactly equal, then past it
        send_sample(15999, 128, 100);
        send_sample(15999, -127, 100);
        send_sample(15999, 127, 5000);
        send_sample(15999, 0, 1);
        // at the landing altitude the timer stops
        send_sample(16000, 0, 100);
        // big drop with slow sink, but the climb hold never runs out: stays on ground
        send_sample(0, 0, 100);
        send_sample(50000, 0, 100);
        send_sample(25999, -100, 100);
        send_sample(0, 0, 100);
        send_sample(0, 0, 5001);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();

            // pick thresholds: lowest, highest, then random ones
            if (p == 0)
            begin
                foreach (reg_vals[i]) reg_vals[i] = '0;
                reg_vals[REG_LANDING_ALT] = 32'h0080_0000;
            end
            else if (p == 1)
            begin
                reg_vals[REG_CLIMB_ALT]     = 32'h007F_FFFF;
                reg_vals[REG_CLIMB_HOLD]    = 32'hFFFF_FFFF;
                reg_vals[REG_FREEFALL_DROP] = 32'h007F_FFFF;
                reg_vals[REG_FREEFALL_SINK] = 32'h0000_7FFF;
                reg_vals[REG_CANOPY_DIRECT] = 32'h007F_FFFF;
                reg_vals[REG_CANOPY_AFTER]  = 32'h007F_FFFF;
                reg_vals[REG_LANDING_ALT]   = 32'h007F_FFFF;
                reg_vals[REG_LANDING_HOLD]  = 32'hFFFF_FFFF;
            end
            else if (p == NUM_PHASES - 1)
            begin
                foreach (reg_vals[i]) reg_vals[i] = $urandom();
            end
            else
            begin
                reg_vals[REG_CLIMB_ALT]     = CFG_DAT_W'(rand_between(0, 200000));
                reg_vals[REG_CLIMB_HOLD]    = CFG_DAT_W'(rand_between(0, 20000));
                reg_vals[REG_FREEFALL_DROP] = CFG_DAT_W'(rand_between(0, 50000));
                reg_vals[REG_FREEFALL_SINK] = CFG_DAT_W'(rand_between(0, 4000));
                reg_vals[REG_CANOPY_DIRECT] = CFG_DAT_W'(rand_between(0, 300000));
                reg_vals[REG_CANOPY_AFTER]  = CFG_DAT_W'(rand_between(0, 150000));
                reg_vals[REG_LANDING_ALT]   = CFG_DAT_W'(rand_between(-20000, 400000));
                reg_vals[REG_LANDING_HOLD]  = CFG_DAT_W'(rand_between(0, 20000));
            end

            // register writes, block idle
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= reg_vals[i];
                cfg_valid <= 1'b1;
                do @(posedge clk); while (!(cfg_valid && cfg_ready));
            end
            cfg_valid <= 1'b0;

            // every third phase runs without idling; one phase floods a stalled sink
            snd_gap_max = (p % 3 == 2) ? 0 : 6;
            rcv_gap_max = (p % 3 == 2) ? 0 : 6;
            if (p == 3)
            begin
                snd_gap_max  = 0;
                rcv_hold_req = LONG_HOLD;
            end

            stop_at = samples_sent + PHASE_ITEMS;
            while (samples_sent < stop_at)
            begin
                if (rand_between(0, 4) == 0)
                begin
                    // noise: any altitude, speed and timestamp
                    repeat (rand_between(1, 5))
                        send_sample(rand_between(ALT_MIN, ALT_MAX), rand_between(VS_MIN, VS_MAX),
                                    $urandom());
                end
                else
                begin
                    ca   = longint'(sb.regs.climb_altitude);
                    ff   = longint'(sb.regs.freefall_drop);
                    sink = longint'(sb.regs.freefall_sink);
                    cd   = longint'(sb.regs.canopy_direct_drop);
                    caf  = longint'(sb.regs.canopy_after_freefall_drop);
                    la   = longint'($signed(sb.regs.landing_altitude));

                    // on the ground below the climb altitude
                    repeat (rand_between(1, 3))
                        send_sample(ca - rand_between(1, 4000), rand_between(-200, 200),
                                    rand_between(100, 2000));

                    // climb: above the threshold past the hold time, sometimes touching it
                    n     = rand_between(3, 7);
                    dt_ms = longint'(sb.regs.climb_hold_ms) / (n - 1) + rand_between(1, 300);
                    alt   = ca + 1;
                    repeat (n)
                    begin
                        alt = (rand_between(0, 5) == 0) ? ca :
                              clamp(alt + rand_between(0, 500), ALT_MIN, ALT_MAX);
                        send_sample(alt, rand_between(0, 400), dt_ms);
                    end

                    // on up to exit altitude
                    repeat (rand_between(1, 4))
                    begin
                        alt = clamp(alt + rand_between(0, 15000), ALT_MIN, ALT_MAX);
                        send_sample(alt, rand_between(0, 600), rand_between(200, 3000));
                    end
                    pk = alt;

                    if (rand_between(0, 3) != 0)
                    begin
                        // exit: fast sink past the freefall drop, fall to deployment depth
                        from_alt = pk - ff - rand_between(1, 2000);
                        to_alt   = pk - caf - rand_between(1, 3000);
                        n        = rand_between(1, 5);
                        for (int i = 0; i <= n; i++)
                            send_sample(from_alt + (to_alt - from_alt) * i / n,
                                        -sink - rand_between(1, 6000), rand_between(100, 1000));
                        // deployment slows the fall
                        repeat (rand_between(1, 3))
                            send_sample(to_alt, rand_between(-159, 159), rand_between(100, 1000));
                    end
                    else
                    begin
                        // big drop without a fast sink
                        to_alt = pk - cd - rand_between(1, 3000);
                        send_sample(to_alt, -rand_between(0, sink), rand_between(100, 1000));
                    end

                    // canopy descent below the landing altitude
                    from_alt = to_alt;
                    to_alt   = la - rand_between(1, 2000);
                    n        = rand_between(1, 4);
                    for (int i = 1; i <= n; i++)
                        send_sample(from_alt + (to_alt - from_alt) * i / n,
                                    rand_between(-400, -130), rand_between(500, 3000));

                    // standing still past the landing hold
                    n     = rand_between(3, 6);
                    dt_ms = longint'(sb.regs.landing_hold_ms) / (n - 1) + rand_between(1, 300);
                    repeat (n)
                        send_sample(to_alt - rand_between(0, 50), rand_between(-127, 127), dt_ms);
                end
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("flight_phase_detector_unit regression: pass");
        else
            $display("flight_phase_detector_unit regression: fail");
        $finish;
    end

endmodule
